// ----- rtl/uve_pkg.sv -----
// ----------------------------------------------------------------------------
// uve_pkg
// Shared types, character codes and lookup functions for the URL value
// encoder: Turkish letter folding, plain and reserved sets, hex digits.
// ----------------------------------------------------------------------------
package uve_pkg;

   // Most bytes one input item can expand to
   localparam int unsigned MaxOut     = 8;
   localparam int unsigned CountWidth = $clog2(MaxOut + 1);
   localparam int unsigned IdxWidth   = $clog2(MaxOut);

   // Characters with dollar escapes
   localparam logic [7:0] CharLt      = 8'h3C;
   localparam logic [7:0] CharGt      = 8'h3E;
   localparam logic [7:0] CharAmp     = 8'h26;
   localparam logic [7:0] CharEq      = 8'h3D;
   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharPlus    = 8'h2B;

   // Byte 0 is the first byte sent
   typedef logic [MaxOut-1:0][7:0] byte_vec_type;

   typedef struct packed {
      byte_vec_type          data;
      logic [CountWidth-1:0] count;
   } enc_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] letter;
   } fold_type;

   // Turn a right-justified string literal into first-byte-at-index-0 order
   function automatic byte_vec_type text_to_vec(input byte_vec_type txt,
                                                input int unsigned  len);
      byte_vec_type vec;
      vec = '0;
      for (int unsigned k = 0; k < MaxOut; k++) begin
         if (k < len) begin
            vec[IdxWidth'(k)] = txt[IdxWidth'(len - 1 - k)];
         end
      end
      return vec;
   endfunction

   // ISO 8859-9 Turkish letters folded to plain ASCII
   function automatic fold_type fold_turkish(input logic [7:0] c);
      fold_type f;
      f.hit = 1'b1;
      case (c)
         8'hC7:   f.letter = "C";
         8'hD0:   f.letter = "G";
         8'hD6:   f.letter = "O";
         8'hDC:   f.letter = "U";
         8'hDD:   f.letter = "I";
         8'hDE:   f.letter = "S";
         8'hE7:   f.letter = "c";
         8'hF0:   f.letter = "g";
         8'hF6:   f.letter = "o";
         8'hFC:   f.letter = "u";
         8'hFD:   f.letter = "i";
         8'hFE:   f.letter = "s";
         default: begin
            f.hit    = 1'b0;
            f.letter = 8'h00;
         end
      endcase
      return f;
   endfunction

   // Letters, digits, -._~ and NUL
   function automatic logic is_plain(input logic [7:0] c);
      logic r;
      case (c) inside
         ["0":"9"], ["A":"Z"], ["a":"z"],
         "-", ".", "_", "~", 8'h00: r = 1'b1;
         default:                   r = 1'b0;
      endcase
      return r;
   endfunction

   // :/?#[]@!$&'()*+,;=
   function automatic logic is_reserved(input logic [7:0] c);
      logic r;
      case (c) inside
         ":", "/", "?", "#", "[", "]", "@", "!", "$", "&",
         8'h27, "(", ")", "*", "+", ",", ";", "=": r = 1'b1;
         default:                                  r = 1'b0;
      endcase
      return r;
   endfunction

   // Lower-case hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = 8'h30 + {4'h0, nib};
      end else begin
         r = 8'h57 + {4'h0, nib};
      end
      return r;
   endfunction

endpackage

// ----- rtl/url_value_encoder_unit.sv -----
// Pipeline: an accepted item is held in the input register, encoded out of
// it and loaded into the byte-group register once that register is free;
// its first result is offered from the byte-group register.
// Throughput: one result item per cycle while rsp_stall is low;
// an input item holds the group register until its results (1 to 8) are
// taken, so plain bytes stream at one item per cycle. A dropped byte leaves
// the input register without loading the group and yields no result.
// Reset: synchronous, active high; clears the pipeline, include_reserved = 1.
// ----------------------------------------------------------------------------
// url_value_encoder_unit
// URL value encoder: dollar escapes, Turkish letter folding, pass-through of
// safe bytes and lower-case percent encoding, one result byte per item.
// ----------------------------------------------------------------------------
module url_value_encoder_unit
   import uve_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_run_last,
   output logic       rsp_value_end
);

   logic       include_reserved_ff, include_reserved_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;
   enc_type    enc;
   logic       drop;
   logic       grp_free;
   logic       consume;
   logic       accept;

   // Configuration register
   assign include_reserved_in = csr_wr_en ? csr_wr_data : include_reserved_ff;

   // Encode the held item
   uve_encoder u_encoder (
      .in_byte          (in_byte_ff),
      .include_reserved (include_reserved_ff),
      .enc              (enc)
   );

   // Bytes that yield nothing and are not last vanish without a result
   assign drop    = (enc.count == '0) && !in_last_ff;
   assign consume = in_valid_ff && (drop || grp_free);
   assign req_stall = in_valid_ff && !consume;
   assign accept  = req_valid && !req_stall;

   // Input register next values
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
         in_last_in  = req_in_last;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         include_reserved_ff <= 1'b1;
         in_valid_ff         <= 1'b0;
      end else begin
         include_reserved_ff <= include_reserved_in;
         in_valid_ff         <= in_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   // Byte group output
   uve_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .load          (in_valid_ff && !drop),
      .load_enc      (enc),
      .load_last     (in_last_ff),
      .free          (grp_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_run_last  (rsp_run_last),
      .rsp_value_end (rsp_value_end)
   );

endmodule

// ----- rtl/uve_encoder.sv -----
// ----------------------------------------------------------------------------
// uve_encoder
// Maps one raw byte to its encoded byte group (0 to 8 bytes) and count.
// ----------------------------------------------------------------------------
module uve_encoder
   import uve_pkg::*;
(
   input  logic [7:0] in_byte,
   input  logic       include_reserved,
   output enc_type    enc
);

   fold_type fold;

   assign fold = fold_turkish(in_byte);

   // Escape, fold, pass or percent-encode
   always_comb begin
      enc = '0;
      case (in_byte)
         CharLt: begin
            enc.data  = text_to_vec(byte_vec_type'("$lt;"), 4);
            enc.count = CountWidth'(4);
         end
         CharGt: begin
            enc.data  = text_to_vec(byte_vec_type'("$gt;"), 4);
            enc.count = CountWidth'(4);
         end
         CharAmp: begin
            enc.data  = text_to_vec(byte_vec_type'("$amp;"), 5);
            enc.count = CountWidth'(5);
         end
         CharEq: begin
            enc.data  = text_to_vec(byte_vec_type'("$eq;"), 4);
            enc.count = CountWidth'(4);
         end
         CharPercent: begin
            enc.data  = text_to_vec(byte_vec_type'("$percnt;"), 8);
            enc.count = CountWidth'(8);
         end
         CharPlus: begin
            enc.data  = text_to_vec(byte_vec_type'("$plus;"), 6);
            enc.count = CountWidth'(6);
         end
         default: begin
            if (in_byte[7]) begin
               // high half: fold Turkish letters, drop anything else
               enc.data[0] = fold.letter;
               enc.count   = fold.hit ? CountWidth'(1) : CountWidth'(0);
            end else if (is_plain(in_byte) ||
                         (!include_reserved && is_reserved(in_byte))) begin
               enc.data[0] = in_byte;
               enc.count   = CountWidth'(1);
            end else begin
               enc.data[0] = "%";
               enc.data[1] = hex_char(in_byte[7:4]);
               enc.data[2] = hex_char(in_byte[3:0]);
               enc.count   = CountWidth'(3);
            end
         end
      endcase
   end

endmodule

// ----- rtl/uve_serializer.sv -----
// ----------------------------------------------------------------------------
// uve_serializer
// Holds one encoded byte group and sends it out one byte per result item,
// or one empty end marker for an empty final group.
// ----------------------------------------------------------------------------
module uve_serializer
   import uve_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  enc_type    load_enc,
   input  logic       load_last,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_run_last,
   output logic       rsp_value_end
);

   logic                  grp_valid_ff, grp_valid_in;
   enc_type               grp_enc_ff, grp_enc_in;
   logic                  grp_last_ff, grp_last_in;
   logic [IdxWidth-1:0]   idx_ff, idx_in;
   logic                  empty;
   logic                  final_byte;
   logic                  fire;
   logic                  done;
   logic [CountWidth-1:0] last_idx;

   // Position of the group's final byte
   assign empty      = (grp_enc_ff.count == '0);
   assign last_idx   = grp_enc_ff.count - CountWidth'(1);
   assign final_byte = empty || ({1'b0, idx_ff} == last_idx);

   // Handshake
   assign fire = grp_valid_ff && !rsp_stall;
   assign done = fire && final_byte;
   assign free = !grp_valid_ff || done;

   // Result fields
   assign rsp_valid     = grp_valid_ff;
   assign rsp_out_byte  = empty ? 8'h00 : grp_enc_ff.data[idx_ff];
   assign rsp_out_valid = !empty;
   assign rsp_run_last  = final_byte;
   assign rsp_value_end = final_byte && grp_last_ff;

   // Next group state
   always_comb begin
      grp_valid_in = grp_valid_ff;
      grp_enc_in   = grp_enc_ff;
      grp_last_in  = grp_last_ff;
      idx_in       = idx_ff;
      if (load && free) begin
         grp_valid_in = 1'b1;
         grp_enc_in   = load_enc;
         grp_last_in  = load_last;
         idx_in       = '0;
      end else if (done) begin
         grp_valid_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + IdxWidth'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         grp_valid_ff <= grp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      grp_enc_ff  <= grp_enc_in;
      grp_last_ff <= grp_last_in;
   end

endmodule
